>>> src/tsst_pkg.sv
// ============================================================================
// tsst_pkg: shared definitions for the two-scope symbol table
// Sizes, operation and status codes, the stored entry and the result record.
// ============================================================================
`default_nettype none

package tsst_pkg;

  // Table sizes and key width.
  localparam int CLASS_DEPTH = 64;
  localparam int SUB_DEPTH   = 64;
  localparam int KEY_BITS    = 32;

  // Keys arrive on 32-bit fields, so no more than 32 bits are ever kept.
  localparam int KEY_W     = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int MAX_DEPTH = (CLASS_DEPTH > SUB_DEPTH) ? CLASS_DEPTH : SUB_DEPTH;
  localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
  localparam int IDX_W     = $clog2(MAX_DEPTH);
  localparam int CLS_AW    = $clog2(CLASS_DEPTH);
  localparam int SUB_AW    = $clog2(SUB_DEPTH);

  // Operation codes.
  localparam logic [1:0] OP_DEFINE = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Symbol kinds; the two argument and local kinds have the upper bit set.
  localparam logic [1:0] KIND_ARG   = 2'd2;
  localparam logic [1:0] KIND_LOCAL = 2'd3;

  // One stored table entry.
  typedef struct packed {
    logic [1:0]       kind;
    logic [IDX_W-1:0] index;
    logic [KEY_W-1:0] ftype;
    logic [KEY_W-1:0] name;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // One result item as it leaves the controller.
  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  kind;
    logic [31:0] ftype;
    logic [5:0]  index;
    logic [1:0]  seg;
    logic [6:0]  count;
  } res_t;

endpackage

`default_nettype wire

>>> src/tsst_ram.sv
// ============================================================================
// tsst_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ============================================================================
`default_nettype none

module tsst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> src/tsst_ctrl.sv
// ============================================================================
// tsst_ctrl: sequencer of the two-scope symbol table
// Executes defines and clears, and scans both scope memories for lookups.
// ============================================================================
`default_nettype none

module tsst_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Input item
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_op,
  input  wire logic [1:0]                    in_kind,
  input  wire logic [31:0]                   in_name,
  input  wire logic [31:0]                   in_type,
  // Result item
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output tsst_pkg::res_t                     res,
  // Class scope memory
  output logic                               cls_we,
  output logic [tsst_pkg::CLS_AW-1:0]        cls_waddr,
  output tsst_pkg::entry_t                   cls_wdata,
  output logic [tsst_pkg::CLS_AW-1:0]        cls_raddr,
  input  wire tsst_pkg::entry_t              cls_rdata,
  // Subroutine scope memory
  output logic                               sub_we,
  output logic [tsst_pkg::SUB_AW-1:0]        sub_waddr,
  output tsst_pkg::entry_t                   sub_wdata,
  output logic [tsst_pkg::SUB_AW-1:0]        sub_raddr,
  input  wire tsst_pkg::entry_t              sub_rdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN_SUB,
    S_SCAN_CLS,
    S_RESULT
  } state_t;

  state_t                          state_r, state_nxt;
  logic [1:0]                      op_r, op_nxt;
  logic [1:0]                      kind_r, kind_nxt;
  logic [tsst_pkg::KEY_W-1:0]      key_r, key_nxt;
  logic [tsst_pkg::KEY_W-1:0]      type_r, type_nxt;
  logic [tsst_pkg::CNT_W-1:0]      cls_fill_r, cls_fill_nxt;
  logic [tsst_pkg::CNT_W-1:0]      sub_fill_r, sub_fill_nxt;
  logic [tsst_pkg::CNT_W-1:0]      cnt_r [4];
  logic [tsst_pkg::CNT_W-1:0]      cnt_nxt [4];
  logic [tsst_pkg::CNT_W-1:0]      idx_r, idx_nxt;
  logic                            pend_r, pend_nxt;
  tsst_pkg::res_t                  res_r, res_nxt;
  tsst_pkg::entry_t                new_entry;

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESULT);

  // The count of the item's kind is taken from the counters after the step.
  always_comb begin
    res       = res_r;
    res.count = 7'(cnt_r[kind_r]);
  end

  // Entry written by a define; both memories are offered the same word.
  always_comb begin
    new_entry.kind  = kind_r;
    new_entry.index = tsst_pkg::IDX_W'(cnt_r[kind_r]);
    new_entry.ftype = type_r;
    new_entry.name  = key_r;
  end

  assign cls_wdata = new_entry;
  assign sub_wdata = new_entry;
  assign cls_waddr = cls_fill_r[tsst_pkg::CLS_AW-1:0];
  assign sub_waddr = sub_fill_r[tsst_pkg::SUB_AW-1:0];
  assign cls_raddr = idx_r[tsst_pkg::CLS_AW-1:0];
  assign sub_raddr = idx_r[tsst_pkg::SUB_AW-1:0];

  // Next-state logic.
  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    kind_nxt     = kind_r;
    key_nxt      = key_r;
    type_nxt     = type_r;
    cls_fill_nxt = cls_fill_r;
    sub_fill_nxt = sub_fill_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    pend_nxt     = pend_r;
    res_nxt      = res_r;
    cls_we       = 1'b0;
    sub_we       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_op;
          kind_nxt  = in_kind;
          key_nxt   = in_name[tsst_pkg::KEY_W-1:0];
          type_nxt  = in_type[tsst_pkg::KEY_W-1:0];
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        res_nxt   = '0;
        state_nxt = S_RESULT;
        case (op_r)
          tsst_pkg::OP_DEFINE: begin
            if (!kind_r[1]) begin
              if (cls_fill_r == tsst_pkg::CNT_W'(tsst_pkg::CLASS_DEPTH)) begin
                res_nxt.status = tsst_pkg::ST_FULL;
              end else begin
                cls_we       = 1'b1;
                cls_fill_nxt = cls_fill_r + tsst_pkg::CNT_W'(1);
              end
            end else begin
              if (sub_fill_r == tsst_pkg::CNT_W'(tsst_pkg::SUB_DEPTH)) begin
                res_nxt.status = tsst_pkg::ST_FULL;
              end else begin
                sub_we       = 1'b1;
                sub_fill_nxt = sub_fill_r + tsst_pkg::CNT_W'(1);
              end
            end
            if (cls_we || sub_we) begin
              cnt_nxt[kind_r] = cnt_r[kind_r] + tsst_pkg::CNT_W'(1);
              res_nxt.status  = tsst_pkg::ST_OK;
              res_nxt.kind    = kind_r;
              res_nxt.ftype   = 32'(type_r);
              res_nxt.index   = 6'(cnt_r[kind_r]);
              res_nxt.seg     = kind_r;
            end
          end
          tsst_pkg::OP_LOOKUP: begin
            idx_nxt   = '0;
            pend_nxt  = 1'b0;
            state_nxt = S_SCAN_SUB;
          end
          tsst_pkg::OP_CLEAR: begin
            sub_fill_nxt                  = '0;
            cnt_nxt[tsst_pkg::KIND_ARG]   = '0;
            cnt_nxt[tsst_pkg::KIND_LOCAL] = '0;
          end
          default: begin
          end
        endcase
      end

      // One read issued and one entry compared per cycle, oldest first.
      S_SCAN_SUB: begin
        if (pend_r && (sub_rdata.name == key_r)) begin
          res_nxt.status = tsst_pkg::ST_OK;
          res_nxt.kind   = sub_rdata.kind;
          res_nxt.ftype  = 32'(sub_rdata.ftype);
          res_nxt.index  = 6'(sub_rdata.index);
          res_nxt.seg    = sub_rdata.kind;
          state_nxt      = S_RESULT;
        end else if (idx_r < sub_fill_r) begin
          idx_nxt  = idx_r + tsst_pkg::CNT_W'(1);
          pend_nxt = 1'b1;
        end else begin
          idx_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = S_SCAN_CLS;
        end
      end

      S_SCAN_CLS: begin
        if (pend_r && (cls_rdata.name == key_r)) begin
          res_nxt.status = tsst_pkg::ST_OK;
          res_nxt.kind   = cls_rdata.kind;
          res_nxt.ftype  = 32'(cls_rdata.ftype);
          res_nxt.index  = 6'(cls_rdata.index);
          res_nxt.seg    = cls_rdata.kind;
          state_nxt      = S_RESULT;
        end else if (idx_r < cls_fill_r) begin
          idx_nxt  = idx_r + tsst_pkg::CNT_W'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt       = 1'b0;
          res_nxt.status = tsst_pkg::ST_MISS;
          state_nxt      = S_RESULT;
        end
      end

      S_RESULT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, counters and registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cls_fill_r <= '0;
      sub_fill_r <= '0;
      cnt_r      <= '{default: '0};
      pend_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cls_fill_r <= cls_fill_nxt;
      sub_fill_r <= sub_fill_nxt;
      cnt_r      <= cnt_nxt;
      pend_r     <= pend_nxt;
    end
    op_r   <= op_nxt;
    kind_r <= kind_nxt;
    key_r  <= key_nxt;
    type_r <= type_nxt;
    idx_r  <= idx_nxt;
    res_r  <= res_nxt;
  end

  // The class scope holds only static and field entries.
  a_cls_fill_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |->
      ((tsst_pkg::CNT_W + 1)'(cnt_r[0]) + (tsst_pkg::CNT_W + 1)'(cnt_r[1]))
        == (tsst_pkg::CNT_W + 1)'(cls_fill_r))
    else $error("class fill differs from static plus field counts");

  // The subroutine scope holds only argument and local entries.
  a_sub_fill_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |->
      ((tsst_pkg::CNT_W + 1)'(cnt_r[2]) + (tsst_pkg::CNT_W + 1)'(cnt_r[3]))
        == (tsst_pkg::CNT_W + 1)'(sub_fill_r))
    else $error("subroutine fill differs from argument plus local counts");

  // An accepted item is executed in the following cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_EXEC))
    else $error("accepted item not executed");

  // A result that is not taken stays offered and unchanged.
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_r)))
    else $error("result dropped or changed while waiting");

endmodule

`default_nettype wire

>>> src/two_scope_symbol_table.sv
// ============================================================================
// two_scope_symbol_table: class and subroutine scope symbol table
// Defines and looks up symbols kept in two scope memories, and clears the subroutine scope.
// ============================================================================
//
//   Channel  Direction  Payload
//   -------  ---------  ----------------------------------------------------
//   in_      slave      tuser: opcode; tdata: kind, name_key, type_key
//   out_     master     tuser: status; tdata: found_kind, found_type,
//                       found_index, segment, kind_count
//
// Items are handled one at a time. A define, a clear or an unused opcode
// passes from acceptance through the execute and result states into the
// output register, and the next item is taken once the sequencer is back in
// idle. A lookup scans the subroutine scope first and then, on a miss, the
// class scope: each scope memory has one read port, and the scan reads one
// entry per cycle.
// Reset clears the fill levels and kind counters; the memories need no
// clearing pass, as only entries below the fill level are ever read.
// The output register lets the next item be accepted while a result waits.
//
`default_nettype none

module two_scope_symbol_table (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // kind[1:0], name_key[33:2], type_key[65:34]
  input  wire logic [1:0]  in_tuser,   // opcode[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // found_kind[1:0], found_type[33:2],
                                       // found_index[39:34], segment[41:40],
                                       // kind_count[48:42]
  output logic [1:0]       out_tuser   // status[1:0]
);

  logic                            res_valid;
  logic                            res_ready;
  tsst_pkg::res_t                  res;
  logic                            cls_we;
  logic [tsst_pkg::CLS_AW-1:0]     cls_waddr;
  logic [tsst_pkg::CLS_AW-1:0]     cls_raddr;
  tsst_pkg::entry_t                cls_wdata;
  tsst_pkg::entry_t                cls_rdata;
  logic                            sub_we;
  logic [tsst_pkg::SUB_AW-1:0]     sub_waddr;
  logic [tsst_pkg::SUB_AW-1:0]     sub_raddr;
  tsst_pkg::entry_t                sub_wdata;
  tsst_pkg::entry_t                sub_rdata;
  logic                            out_valid_r, out_valid_nxt;
  tsst_pkg::res_t                  out_res_r;

  // Sequencer.
  tsst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_kind   (in_tdata[1:0]),
    .in_name   (in_tdata[33:2]),
    .in_type   (in_tdata[65:34]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cls_we    (cls_we),
    .cls_waddr (cls_waddr),
    .cls_wdata (cls_wdata),
    .cls_raddr (cls_raddr),
    .cls_rdata (cls_rdata),
    .sub_we    (sub_we),
    .sub_waddr (sub_waddr),
    .sub_wdata (sub_wdata),
    .sub_raddr (sub_raddr),
    .sub_rdata (sub_rdata)
  );

  // Class scope entries.
  tsst_ram #(
    .WIDTH (tsst_pkg::ENTRY_W),
    .DEPTH (tsst_pkg::CLASS_DEPTH)
  ) u_cls_ram (
    .clk     (clk),
    .wr_en   (cls_we),
    .wr_addr (cls_waddr),
    .wr_data (cls_wdata),
    .rd_addr (cls_raddr),
    .rd_data (cls_rdata)
  );

  // Subroutine scope entries.
  tsst_ram #(
    .WIDTH (tsst_pkg::ENTRY_W),
    .DEPTH (tsst_pkg::SUB_DEPTH)
  ) u_sub_ram (
    .clk     (clk),
    .wr_en   (sub_we),
    .wr_addr (sub_waddr),
    .wr_data (sub_wdata),
    .rd_addr (sub_raddr),
    .rd_data (sub_rdata)
  );

  // Output register: loads when empty or when its item is being taken.
  assign res_ready     = !out_valid_r || out_tready;
  assign out_valid_nxt = res_valid || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {7'd0, out_res_r.count, out_res_r.seg, out_res_r.index,
                       out_res_r.ftype, out_res_r.kind};

endmodule

`default_nettype wire
